### rtl/gregorian_date_add_days_top_macros.svh
// Assertion macros shared by the date adder modules.
`ifndef GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdad assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdad assertion failed");

`endif

### rtl/gdad_pkg.sv
package gdad_pkg;

    localparam int MONTHS_PER_YEAR  = 12;
    localparam int DAYS_COMMON_YEAR = 365;
    localparam int LEAP_CYCLE       = 400;
    localparam int CENTURY          = 100;
    localparam int INIT_STEPS       = 6;

    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [13:0] year_t;
    typedef logic [14:0] add_t;
    typedef logic [15:0] rem_t;
    typedef logic [8:0]  cycle_pos_t;
    typedef logic [2:0]  step_t;

    typedef struct packed {
        logic  load_in;
        logic  init_step;
        step_t init_shift;
        logic  doy;
        logic  year_step;
        logic  month_step;
        logic  load_out;
    } gdad_cmd_t;

    typedef struct packed {
        logic rem_gt_year;
        logic rem_gt_month;
    } gdad_sts_t;

    // Days before the first of each month in a common year, months 0..15.
    localparam logic [8:0] DAYS_BEFORE_TAB [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    // Leap test from the position of the year within the 400-year cycle.
    function automatic logic is_leap(cycle_pos_t pos);
        logic cent;
        cent = (pos inside {9'(CENTURY), 9'(2 * CENTURY), 9'(3 * CENTURY)});
        return (pos == '0) || ((pos[1:0] == 2'b00) && !cent);
    endfunction

    function automatic day_t month_len(month_t m, logic leap);
        day_t len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of all months before month m of the year, months out of range included.
    function automatic logic [8:0] days_before(month_t m, logic leap);
        logic extra;
        extra = leap && (m >= 4'd3);
        return DAYS_BEFORE_TAB[m] + {8'd0, extra};
    endfunction

endpackage

### rtl/gdad_if.sv
interface gdad_in_if;
    logic                 valid;
    logic                 ready;
    gdad_pkg::day_t       start_day;
    gdad_pkg::month_t     start_month;
    gdad_pkg::year_t      start_year;
    gdad_pkg::add_t       days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface gdad_out_if;
    logic                 valid;
    logic                 ready;
    gdad_pkg::day_t       result_day;
    gdad_pkg::month_t     result_month;
    gdad_pkg::year_t      result_year;

    modport source (output valid, result_day, result_month, result_year, input ready);
    modport sink   (input valid, result_day, result_month, result_year, output ready);
endinterface

### rtl/gdad_ctrl.sv
`include "gregorian_date_add_days_top_macros.svh"

module gdad_ctrl import gdad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  gdad_sts_t sts,
    output gdad_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DOY,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = step_t'(INIT_STEPS - 1);
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_step  = 1'b1;
                cmd.init_shift = step_reg;
                if (step_reg == '0)
                begin
                    state_next = ST_DOY;
                end
                else
                begin
                    step_next = step_reg - 3'd1;
                end
            end
            ST_DOY:
            begin
                cmd.doy    = 1'b1;
                state_next = ST_YEARS;
            end
            ST_YEARS:
            begin
                if (sts.rem_gt_year)
                begin
                    cmd.year_step = 1'b1;
                end
                else
                begin
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS:
            begin
                if (sts.rem_gt_month)
                begin
                    cmd.month_step = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `GDAD_ASSERT_NEXT(a_accept_starts_init, clk, rst_n, in_valid && in_ready, state_reg == ST_INIT)
    `GDAD_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready)
    `GDAD_ASSERT_NOW(a_single_command, clk, rst_n, 1'b1, $onehot0({cmd.load_in, cmd.init_step, cmd.doy, cmd.year_step, cmd.month_step, cmd.load_out}))

endmodule

### rtl/gdad_dp.sv
`include "gregorian_date_add_days_top_macros.svh"

module gdad_dp import gdad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gdad_cmd_t cmd,
    output gdad_sts_t sts,
    input  day_t      start_day,
    input  month_t    start_month,
    input  year_t     start_year,
    input  add_t      days_to_add,
    output day_t      result_day,
    output month_t    result_month,
    output year_t     result_year
);

    day_t   day_reg;
    month_t smonth_reg;
    add_t   add_reg;
    year_t  year_reg, year_next;
    year_t  pos_reg, pos_next;
    rem_t   rem_reg, rem_next;
    month_t month_reg, month_next;
    day_t   res_day_reg;
    month_t res_month_reg;
    year_t  res_year_reg;

    logic       leap;
    logic [8:0] year_len;
    day_t       cur_len;
    year_t      init_thr;

    // The position counter holds the year modulo 400 once the reduction steps are done.
    assign leap     = is_leap(pos_reg[8:0]);
    assign year_len = 9'(DAYS_COMMON_YEAR) + {8'd0, leap};
    assign cur_len  = month_len(month_reg, leap);
    assign init_thr = year_t'(LEAP_CYCLE) << cmd.init_shift;

    assign sts.rem_gt_year  = rem_reg > {7'd0, year_len};
    assign sts.rem_gt_month = rem_reg > {11'd0, cur_len};

    always_comb
    begin
        year_next  = year_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        month_next = month_reg;
        if (cmd.load_in)
        begin
            year_next = start_year;
            pos_next  = start_year;
        end
        if (cmd.init_step && (pos_reg >= init_thr))
        begin
            pos_next = pos_reg - init_thr;
        end
        if (cmd.doy)
        begin
            rem_next   = {1'b0, add_reg} + {11'd0, day_reg}
                       + {7'd0, days_before(smonth_reg, leap)};
            month_next = 4'd1;
        end
        if (cmd.year_step)
        begin
            rem_next  = rem_reg - {7'd0, year_len};
            year_next = year_reg + 14'd1;
            pos_next  = (pos_reg == year_t'(LEAP_CYCLE - 1)) ? '0 : pos_reg + 14'd1;
        end
        if (cmd.month_step)
        begin
            rem_next   = rem_reg - {11'd0, cur_len};
            month_next = month_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            day_reg    <= start_day;
            smonth_reg <= start_month;
            add_reg    <= days_to_add;
        end
        year_reg  <= year_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        month_reg <= month_next;
        if (cmd.load_out)
        begin
            res_day_reg   <= rem_reg[4:0];
            res_month_reg <= month_reg;
            res_year_reg  <= year_reg;
        end
    end

    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;

    `GDAD_ASSERT_NOW(a_pos_reduced, clk, rst_n, cmd.doy || cmd.year_step, pos_reg < year_t'(LEAP_CYCLE))
    `GDAD_ASSERT_NOW(a_month_walk_in_year, clk, rst_n, cmd.month_step, month_reg < 4'(MONTHS_PER_YEAR))

endmodule

### rtl/gregorian_date_add_days_top.sv
// From input accept to output valid, a word passes the reduction and day-of-year steps,
// then Y year steps and M month steps, where Y is the number of whole years skipped (at
// most 90) and M the number of months walked (at most 11). Inputs are taken only in idle.
// A finished word waits in the output register while the next input word is taken.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and clears out valid.

// The controller first reduces the start year modulo 400 in six conditional subtract
// steps (12800 down to 400), which gives the leap position that then follows every year
// increment. Next the day of the year is formed from a constant table of month offsets.
// Whole years are then subtracted one per cycle while the remaining count exceeds the
// year length, and finally months are subtracted one per cycle from January onward.
// Skipping a whole year is exact: when the count exceeds the year length, the month walk
// would pass through all twelve months of that year.
module gregorian_date_add_days_top import gdad_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    gdad_in_if.sink  in_ch,
    gdad_out_if.source out_ch
);

    gdad_cmd_t cmd;
    gdad_sts_t sts;

    // The controller sequences the reduction, year skip and month walk.
    gdad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the running count, the year, its leap position and the result.
    gdad_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .start_day    (in_ch.start_day),
        .start_month  (in_ch.start_month),
        .start_year   (in_ch.start_year),
        .days_to_add  (in_ch.days_to_add),
        .result_day   (out_ch.result_day),
        .result_month (out_ch.result_month),
        .result_year  (out_ch.result_year)
    );

endmodule
